/* src/cnpq_pkg.sv */
`default_nettype none

package cnpq_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int GRAD_W  = FRAC_W + 2;
  localparam int RAD_W   = COORD_W - 1;
  localparam int EPS_W   = FRAC_W;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int EXT_W   = COORD_W + 4;
  localparam int LEN_W   = COORD_W;
  localparam int T_W     = 32;
  localparam int DQ_W    = 34;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [2:0] REG_SEG_START_X = 3'd0;
  localparam logic [2:0] REG_SEG_START_Y = 3'd1;
  localparam logic [2:0] REG_SEG_END_X   = 3'd2;
  localparam logic [2:0] REG_SEG_END_Y   = 3'd3;
  localparam logic [2:0] REG_RADIUS      = 3'd4;
  localparam logic [2:0] REG_GRAD_EPS    = 3'd5;
  localparam logic [2:0] REG_FALLBACK_X  = 3'd6;
  localparam logic [2:0] REG_FALLBACK_Y  = 3'd7;

  localparam logic [FRAC_W:0] GRAD_ONE = (FRAC_W + 1)'(1) << FRAC_W;

  localparam logic signed [EXT_W-1:0] DIFF_MAX_X  = EXT_W'(64'sd2147483647);
  localparam logic signed [EXT_W-1:0] DIFF_MIN_X  = -EXT_W'(64'sd2147483647);
  localparam logic signed [EXT_W-1:0] COORD_MAX_X = EXT_W'(64'sd2147483647);
  localparam logic signed [EXT_W-1:0] COORD_MIN_X = -EXT_W'(64'sd2147483648);

  typedef enum logic [1:0] {
    CLS_END,
    CLS_START,
    CLS_LERP
  } cls_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [RAD_W-1:0]          rad;
    logic [EPS_W-1:0]          eps;
    logic signed [GRAD_W-1:0]  fnx;
    logic signed [GRAD_W-1:0]  fny;
  } cfg_t;

  typedef struct packed {
    cls_t                      cls;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [PROD_W-1:0]         num;
    logic [PROD_W-1:0]         den;
  } qent_t;

  typedef struct packed {
    cls_t                      cls;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } td_side_t;

  typedef struct packed {
    logic signed [EXT_W-1:0]   cx;
    logic signed [EXT_W-1:0]   cy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } sq_side_t;

  typedef struct packed {
    logic signed [EXT_W-1:0] cx;
    logic signed [EXT_W-1:0] cy;
    logic                    sgn_x;
    logic                    sgn_y;
    logic [LEN_W-1:0]        len;
    logic [3:0]              ovf;
  } fd_side_t;

  // differences clamp symmetrically to +-(2^31-1)
  function automatic logic signed [COORD_W-1:0] sat_diff(input logic signed [EXT_W-1:0] v);
    if (v > DIFF_MAX_X) begin
      return DIFF_MAX_X[COORD_W-1:0];
    end else if (v < DIFF_MIN_X) begin
      return DIFF_MIN_X[COORD_W-1:0];
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
    if (v > COORD_MAX_X) begin
      return COORD_MAX_X[COORD_W-1:0];
    end else if (v < COORD_MIN_X) begin
      return COORD_MIN_X[COORD_W-1:0];
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

  // input never reaches -2^31 after saturation
  function automatic logic [COORD_W-2:0] mag31(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] n;
    n = -v;
    return v[COORD_W-1] ? n[COORD_W-2:0] : v[COORD_W-2:0];
  endfunction

endpackage

`default_nettype wire

/* src/capsule_nearest_point_query.sv */
// throughput: one request per cycle unless out_ready stalls the output; the fraction divide, square root and the
//   four final divides are pipelines that retire one quotient or root bit per stage
// a four-entry queue between front and back absorbs output stalls
// reset: synchronous active-low; clears valids and queue, loads register defaults
`default_nettype none

module capsule_nearest_point_query import cnpq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [COORD_W-1:0]        cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_nearest_x,
  output logic signed [COORD_W-1:0] out_nearest_y,
  output logic signed [COORD_W-1:0] out_signed_distance,
  output logic signed [GRAD_W-1:0]  out_gradient_x,
  output logic signed [GRAD_W-1:0]  out_gradient_y
);

  cfg_t  cfg_r;
  logic  fq_valid, fq_ready, bq_valid, bq_ready;
  qent_t fq_data, bq_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sx  <= '0;
      cfg_r.sy  <= '0;
      cfg_r.ex  <= '0;
      cfg_r.ey  <= '0;
      cfg_r.rad <= '0;
      cfg_r.eps <= EPS_W'(1);
      cfg_r.fnx <= '0;
      cfg_r.fny <= $signed({1'b0, GRAD_ONE});
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEG_START_X: cfg_r.sx  <= cfg_wdata;
        REG_SEG_START_Y: cfg_r.sy  <= cfg_wdata;
        REG_SEG_END_X:   cfg_r.ex  <= cfg_wdata;
        REG_SEG_END_Y:   cfg_r.ey  <= cfg_wdata;
        REG_RADIUS:      cfg_r.rad <= cfg_wdata[RAD_W-1:0];
        REG_GRAD_EPS:    cfg_r.eps <= cfg_wdata[EPS_W-1:0];
        REG_FALLBACK_X:  cfg_r.fnx <= cfg_wdata[GRAD_W-1:0];
        REG_FALLBACK_Y:  cfg_r.fny <= cfg_wdata[GRAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cnpq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_data     (fq_data)
  );

  cnpq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  cnpq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_valid             (bq_valid),
    .q_ready             (bq_ready),
    .q_data              (bq_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_nearest_x       (out_nearest_x),
    .out_nearest_y       (out_nearest_y),
    .out_signed_distance (out_signed_distance),
    .out_gradient_x      (out_gradient_x),
    .out_gradient_y      (out_gradient_y)
  );

endmodule

`default_nettype wire

/* src/cnpq_front.sv */
`default_nettype none

module cnpq_front import cnpq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  output logic                      q_valid,
  input  logic                      q_ready,
  output qent_t                     q_data
);

  logic en;

  logic                      f1_v_r;
  logic signed [COORD_W-1:0] f1_px_r, f1_py_r, f1_dx_r, f1_dy_r, f1_qx_r, f1_qy_r;

  logic                      f2_v_r;
  logic signed [COORD_W-1:0] f2_px_r, f2_py_r, f2_dx_r, f2_dy_r;
  logic signed [PROD_W-1:0]  f2_pnx_r, f2_pny_r, f2_pdx_r, f2_pdy_r;

  logic                      f3_v_r;
  qent_t                     f3_r;

  logic signed [PROD_W:0]    num_w, den_w;
  cls_t                      cls_w;

  assign en       = !f3_v_r || q_ready;
  assign in_ready = en;
  assign q_valid  = f3_v_r;
  assign q_data   = f3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_px_r <= in_point_x;
      f1_py_r <= in_point_y;
      f1_dx_r <= sat_diff(EXT_W'(cfg.sx) - EXT_W'(cfg.ex));
      f1_dy_r <= sat_diff(EXT_W'(cfg.sy) - EXT_W'(cfg.ey));
      f1_qx_r <= sat_diff(EXT_W'(in_point_x) - EXT_W'(cfg.ex));
      f1_qy_r <= sat_diff(EXT_W'(in_point_y) - EXT_W'(cfg.ey));

      f2_px_r  <= f1_px_r;
      f2_py_r  <= f1_py_r;
      f2_dx_r  <= f1_dx_r;
      f2_dy_r  <= f1_dy_r;
      f2_pnx_r <= f1_dx_r * f1_qx_r;
      f2_pny_r <= f1_dy_r * f1_qy_r;
      f2_pdx_r <= f1_dx_r * f1_dx_r;
      f2_pdy_r <= f1_dy_r * f1_dy_r;

      f3_r.cls <= cls_w;
      f3_r.px  <= f2_px_r;
      f3_r.py  <= f2_py_r;
      f3_r.dx  <= f2_dx_r;
      f3_r.dy  <= f2_dy_r;
      f3_r.num <= num_w[PROD_W-1:0];
      f3_r.den <= den_w[PROD_W-1:0];
    end
  end

  // classify the projection: before end, beyond start, or inside
  always_comb begin
    num_w = (PROD_W + 1)'(f2_pnx_r) + (PROD_W + 1)'(f2_pny_r);
    den_w = (PROD_W + 1)'(f2_pdx_r) + (PROD_W + 1)'(f2_pdy_r);
    priority if (den_w == '0 || num_w <= 0) begin
      cls_w = CLS_END;
    end else if (num_w >= den_w) begin
      cls_w = CLS_START;
    end else begin
      cls_w = CLS_LERP;
    end
  end

endmodule

`default_nettype wire

/* src/cnpq_queue.sv */
`default_nettype none

module cnpq_queue import cnpq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  qent_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output qent_t out_data
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push, pop;

  assign in_ready  = count_r != QCNT_W'(QDEPTH);
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

/* src/cnpq_div_pipe.sv */
`default_nettype none

// restoring divider, one quotient bit per stage, lanes share the divisor
module cnpq_div_pipe #(
  parameter int LANES = 1,
  parameter int DW    = 32,
  parameter int QW    = 32,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][DW-1:0]     in_rem,
  input  logic [LANES-1:0][QW-1:0]     in_lo,
  input  logic [DW-1:0]                in_den,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [LANES-1:0][QW-1:0]     out_q,
  output logic [SW-1:0]                out_side
);

  logic                     v_r    [QW];
  logic [LANES-1:0][DW-1:0] rem_r  [QW];
  logic [LANES-1:0][QW-1:0] lo_r   [QW];
  logic [DW-1:0]            den_r  [QW];
  logic [SW-1:0]            side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     sv;
    logic [LANES-1:0][DW-1:0] srem;
    logic [LANES-1:0][QW-1:0] slo;
    logic [DW-1:0]            sden;
    logic [SW-1:0]            sside;
    logic [LANES-1:0][DW-1:0] nrem;
    logic [LANES-1:0][QW-1:0] nlo;

    if (k == 0) begin : g_first
      assign sv    = in_valid;
      assign srem  = in_rem;
      assign slo   = in_lo;
      assign sden  = in_den;
      assign sside = in_side;
    end else begin : g_next
      assign sv    = v_r[k-1];
      assign srem  = rem_r[k-1];
      assign slo   = lo_r[k-1];
      assign sden  = den_r[k-1];
      assign sside = side_r[k-1];
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb begin : p_step
      logic [DW:0] tr;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        tr = {srem[l], slo[l][QW-1]};
        ge = tr >= {1'b0, sden};
        if (ge) begin
          tr = tr - {1'b0, sden};
        end
        nrem[l] = tr[DW-1:0];
        nlo[l]  = {slo[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= nrem;
        lo_r[k]   <= nlo;
        den_r[k]  <= sden;
        side_r[k] <= sside;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = lo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire

/* src/cnpq_sqrt_pipe.sv */
`default_nettype none

// digit-by-digit square root of a 64-bit value, one root bit per stage
module cnpq_sqrt_pipe import cnpq_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [PROD_W-1:0]    in_val,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic [LEN_W-1:0]     out_root,
  output logic [LEN_W+1:0]     out_rem,
  output logic [SW-1:0]        out_side
);

  localparam int NS = PROD_W / 2;

  logic              v_r    [NS];
  logic [PROD_W-1:0] val_r  [NS];
  logic [LEN_W+1:0]  rem_r  [NS];
  logic [LEN_W-1:0]  root_r [NS];
  logic [SW-1:0]     side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic              sv;
    logic [PROD_W-1:0] sval;
    logic [LEN_W+1:0]  srem;
    logic [LEN_W-1:0]  sroot;
    logic [SW-1:0]     sside;
    logic [LEN_W+3:0]  tr, trial;
    logic              ge;
    logic [LEN_W+3:0]  diff;

    if (k == 0) begin : g_first
      assign sv    = in_valid;
      assign sval  = in_val;
      assign srem  = '0;
      assign sroot = '0;
      assign sside = in_side;
    end else begin : g_next
      assign sv    = v_r[k-1];
      assign sval  = val_r[k-1];
      assign srem  = rem_r[k-1];
      assign sroot = root_r[k-1];
      assign sside = side_r[k-1];
    end

    assign tr    = {srem, sval[PROD_W-1:PROD_W-2]};
    assign trial = {2'b00, sroot, 2'b01};
    assign ge    = tr >= trial;
    assign diff  = ge ? tr - trial : tr;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= {sval[PROD_W-3:0], 2'b00};
        rem_r[k]  <= diff[LEN_W+1:0];
        root_r[k] <= {sroot[LEN_W-2:0], ge};
        side_r[k] <= sside;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_rem   = rem_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

`default_nettype wire

/* src/cnpq_back.sv */
`default_nettype none

module cnpq_back import cnpq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  qent_t                     q_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_nearest_x,
  output logic signed [COORD_W-1:0] out_nearest_y,
  output logic signed [COORD_W-1:0] out_signed_distance,
  output logic signed [GRAD_W-1:0]  out_gradient_x,
  output logic signed [GRAD_W-1:0]  out_gradient_y
);

  localparam int TDS_W = $bits(td_side_t);
  localparam int SQS_W = $bits(sq_side_t);
  localparam int FDS_W = $bits(fd_side_t);

  logic adv;

  // projection fraction
  td_side_t              td_in_side, td_side;
  logic                  td_v;
  logic [0:0][T_W-1:0]   td_q;

  // lerp and offset stages
  logic                      l1_v_r;
  cls_t                      l1_cls_r;
  logic signed [COORD_W-1:0] l1_px_r, l1_py_r;
  logic                      l1_sx_r, l1_sy_r;
  logic [COORD_W+T_W-2:0]    l1_mx_r, l1_my_r;

  logic [PROD_W-1:0]         rnd_x, rnd_y;
  logic signed [EXT_W-1:0]   cx_w, cy_w;

  logic                      l2_v_r;
  logic signed [COORD_W-1:0] l2_px_r, l2_py_r;
  logic signed [EXT_W-1:0]   l2_cx_r, l2_cy_r;

  logic                      l3_v_r;
  logic signed [EXT_W-1:0]   l3_cx_r, l3_cy_r;
  logic signed [COORD_W-1:0] l3_ex_r, l3_ey_r;

  logic                      l4_v_r;
  logic signed [EXT_W-1:0]   l4_cx_r, l4_cy_r;
  logic signed [COORD_W-1:0] l4_ex_r, l4_ey_r;
  logic signed [PROD_W-1:0]  l4_sqx_r, l4_sqy_r;

  // length
  sq_side_t          sq_in_side, sq_side;
  logic [PROD_W-1:0] sq_val;
  logic              sq_v;
  logic [LEN_W-1:0]  sq_root;
  logic [LEN_W+1:0]  sq_rem;

  logic                      s1_v_r;
  logic [LEN_W-1:0]          s1_len_r;
  logic [2*RAD_W-1:0]        s1_pex_r, s1_pey_r;
  logic [COORD_W-2:0]        s1_mex_r, s1_mey_r;
  logic                      s1_sgx_r, s1_sgy_r;
  logic signed [EXT_W-1:0]   s1_cx_r, s1_cy_r;

  logic [2*RAD_W:0]          nx_w, ny_w;
  logic [COORD_W+FRAC_W-1:0] gx_w, gy_w;
  logic [3:0][LEN_W-1:0]     hi_w;
  logic [3:0][DQ_W-1:0]      lo_w;
  logic [3:0]                ovf_w;

  logic                  s2_v_r;
  logic [3:0][LEN_W-1:0] s2_rem_r;
  logic [3:0][DQ_W-1:0]  s2_lo_r;
  fd_side_t              s2_side_r;

  // final divides
  fd_side_t              fd_side;
  logic                  fd_v;
  logic [3:0][DQ_W-1:0]  fd_q;
  logic [3:0][DQ_W:0]    qe;

  logic signed [EXT_W-1:0]  nxs_w, nys_w, dist_w;
  logic [FRAC_W:0]          gmx_w, gmy_w;
  logic signed [COORD_W-1:0] nx_o, ny_o;
  logic signed [GRAD_W-1:0] gxo_w, gyo_w;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] nx_r, ny_r, dist_r;
  logic signed [GRAD_W-1:0]  gx_r, gy_r;

  assign adv     = !out_valid_r || out_ready;
  assign q_ready = adv;

  assign td_in_side.cls = q_data.cls;
  assign td_in_side.px  = q_data.px;
  assign td_in_side.py  = q_data.py;
  assign td_in_side.dx  = q_data.dx;
  assign td_in_side.dy  = q_data.dy;

  cnpq_div_pipe #(
    .LANES (1),
    .DW    (PROD_W),
    .QW    (T_W),
    .SW    (TDS_W)
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (q_valid),
    .in_rem    (q_data.num),
    .in_lo     ('0),
    .in_den    (q_data.den),
    .in_side   (td_in_side),
    .out_valid (td_v),
    .out_q     (td_q),
    .out_side  (td_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_v_r <= 1'b0;
      l2_v_r <= 1'b0;
      l3_v_r <= 1'b0;
      l4_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      l1_v_r <= td_v;
      l2_v_r <= l1_v_r;
      l3_v_r <= l2_v_r;
      l4_v_r <= l3_v_r;
      s1_v_r <= sq_v;
      s2_v_r <= s1_v_r;
    end
  end

  // closest segment point: end, start, or end + round(d * t)
  always_comb begin
    rnd_x = {1'b0, l1_mx_r} + (PROD_W'(1) << (T_W - 1));
    rnd_y = {1'b0, l1_my_r} + (PROD_W'(1) << (T_W - 1));
    unique case (l1_cls_r)
      CLS_END: begin
        cx_w = EXT_W'(cfg.ex);
        cy_w = EXT_W'(cfg.ey);
      end
      CLS_START: begin
        cx_w = EXT_W'(cfg.sx);
        cy_w = EXT_W'(cfg.sy);
      end
      CLS_LERP: begin
        cx_w = l1_sx_r ? EXT_W'(cfg.ex) - $signed({4'b0000, rnd_x[PROD_W-1:T_W]})
                       : EXT_W'(cfg.ex) + $signed({4'b0000, rnd_x[PROD_W-1:T_W]});
        cy_w = l1_sy_r ? EXT_W'(cfg.ey) - $signed({4'b0000, rnd_y[PROD_W-1:T_W]})
                       : EXT_W'(cfg.ey) + $signed({4'b0000, rnd_y[PROD_W-1:T_W]});
      end
      default: begin
        cx_w = EXT_W'(cfg.ex);
        cy_w = EXT_W'(cfg.ey);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_cls_r <= td_side.cls;
      l1_px_r  <= td_side.px;
      l1_py_r  <= td_side.py;
      l1_sx_r  <= td_side.dx[COORD_W-1];
      l1_sy_r  <= td_side.dy[COORD_W-1];
      l1_mx_r  <= mag31(td_side.dx) * td_q[0];
      l1_my_r  <= mag31(td_side.dy) * td_q[0];

      l2_px_r <= l1_px_r;
      l2_py_r <= l1_py_r;
      l2_cx_r <= cx_w;
      l2_cy_r <= cy_w;

      l3_cx_r <= l2_cx_r;
      l3_cy_r <= l2_cy_r;
      l3_ex_r <= sat_diff(EXT_W'(l2_px_r) - l2_cx_r);
      l3_ey_r <= sat_diff(EXT_W'(l2_py_r) - l2_cy_r);

      l4_cx_r  <= l3_cx_r;
      l4_cy_r  <= l3_cy_r;
      l4_ex_r  <= l3_ex_r;
      l4_ey_r  <= l3_ey_r;
      l4_sqx_r <= l3_ex_r * l3_ex_r;
      l4_sqy_r <= l3_ey_r * l3_ey_r;
    end
  end

  assign sq_val        = $unsigned(l4_sqx_r) + $unsigned(l4_sqy_r);
  assign sq_in_side.cx = l4_cx_r;
  assign sq_in_side.cy = l4_cy_r;
  assign sq_in_side.ex = l4_ex_r;
  assign sq_in_side.ey = l4_ey_r;

  cnpq_sqrt_pipe #(
    .SW (SQS_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (l4_v_r),
    .in_val    (sq_val),
    .in_side   (sq_in_side),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_rem   (sq_rem),
    .out_side  (sq_side)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      // round to nearest: remainder above the root means past the half
      s1_len_r <= sq_root + LEN_W'(sq_rem > {2'b00, sq_root});
      s1_pex_r <= mag31(sq_side.ex) * cfg.rad;
      s1_pey_r <= mag31(sq_side.ey) * cfg.rad;
      s1_mex_r <= mag31(sq_side.ex);
      s1_mey_r <= mag31(sq_side.ey);
      s1_sgx_r <= sq_side.ex[COORD_W-1];
      s1_sgy_r <= sq_side.ey[COORD_W-1];
      s1_cx_r  <= sq_side.cx;
      s1_cy_r  <= sq_side.cy;
    end
  end

  // dividends with half the divisor added, split into a high remainder
  // and the low bits that the divider shifts in
  always_comb begin
    nx_w = {1'b0, s1_pex_r} + (2 * RAD_W + 1)'(s1_len_r >> 1);
    ny_w = {1'b0, s1_pey_r} + (2 * RAD_W + 1)'(s1_len_r >> 1);
    gx_w = {1'b0, s1_mex_r, {FRAC_W{1'b0}}} + (COORD_W + FRAC_W)'(s1_len_r >> 1);
    gy_w = {1'b0, s1_mey_r, {FRAC_W{1'b0}}} + (COORD_W + FRAC_W)'(s1_len_r >> 1);
    hi_w[0] = LEN_W'(nx_w[2*RAD_W:DQ_W]);
    hi_w[1] = LEN_W'(ny_w[2*RAD_W:DQ_W]);
    hi_w[2] = LEN_W'(gx_w[COORD_W+FRAC_W-1:DQ_W]);
    hi_w[3] = LEN_W'(gy_w[COORD_W+FRAC_W-1:DQ_W]);
    lo_w[0] = nx_w[DQ_W-1:0];
    lo_w[1] = ny_w[DQ_W-1:0];
    lo_w[2] = gx_w[DQ_W-1:0];
    lo_w[3] = gy_w[DQ_W-1:0];
    for (int l = 0; l < 4; l++) begin
      ovf_w[l] = hi_w[l] >= s1_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rem_r        <= hi_w;
      s2_lo_r         <= lo_w;
      s2_side_r.cx    <= s1_cx_r;
      s2_side_r.cy    <= s1_cy_r;
      s2_side_r.sgn_x <= s1_sgx_r;
      s2_side_r.sgn_y <= s1_sgy_r;
      s2_side_r.len   <= s1_len_r;
      s2_side_r.ovf   <= ovf_w;
    end
  end

  cnpq_div_pipe #(
    .LANES (4),
    .DW    (LEN_W),
    .QW    (DQ_W),
    .SW    (FDS_W)
  ) u_fdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s2_v_r),
    .in_rem    (s2_rem_r),
    .in_lo     (s2_lo_r),
    .in_den    (s2_side_r.len),
    .in_side   (s2_side_r),
    .out_valid (fd_v),
    .out_q     (fd_q),
    .out_side  (fd_side)
  );

  // overflowed quotients stand in as 2^34, far past any saturation point
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qe[l] = fd_side.ovf[l] ? ((DQ_W + 1)'(1) << DQ_W) : {1'b0, fd_q[l]};
    end
    nxs_w = fd_side.sgn_x ? fd_side.cx - $signed({1'b0, qe[0]})
                          : fd_side.cx + $signed({1'b0, qe[0]});
    nys_w = fd_side.sgn_y ? fd_side.cy - $signed({1'b0, qe[1]})
                          : fd_side.cy + $signed({1'b0, qe[1]});
    if (fd_side.len == '0) begin
      nx_o = sat_coord(fd_side.cx);
      ny_o = sat_coord(fd_side.cy);
    end else begin
      nx_o = sat_coord(nxs_w);
      ny_o = sat_coord(nys_w);
    end
    dist_w = $signed({4'b0000, fd_side.len}) - $signed({5'b00000, cfg.rad});
    gmx_w  = (fd_side.ovf[2] || fd_q[2][DQ_W-1:FRAC_W] != '0) ? GRAD_ONE
                                                              : fd_q[2][FRAC_W:0];
    gmy_w  = (fd_side.ovf[3] || fd_q[3][DQ_W-1:FRAC_W] != '0) ? GRAD_ONE
                                                              : fd_q[3][FRAC_W:0];
    if (fd_side.len > LEN_W'(cfg.eps)) begin
      gxo_w = fd_side.sgn_x ? -$signed({1'b0, gmx_w}) : $signed({1'b0, gmx_w});
      gyo_w = fd_side.sgn_y ? -$signed({1'b0, gmy_w}) : $signed({1'b0, gmy_w});
    end else begin
      gxo_w = cfg.fnx;
      gyo_w = cfg.fny;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fd_v) begin
      nx_r   <= nx_o;
      ny_r   <= ny_o;
      dist_r <= sat_coord(dist_w);
      gx_r   <= gxo_w;
      gy_r   <= gyo_w;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_nearest_x       = nx_r;
  assign out_nearest_y       = ny_r;
  assign out_signed_distance = dist_r;
  assign out_gradient_x      = gx_r;
  assign out_gradient_y      = gy_r;

endmodule

`default_nettype wire
